// ----- sv/vos_pkg.sv -----
// Shared widths, codes and types for the voxel occupancy scatter block.
package vos_pkg;

  // Operation codes carried by the func field.
  localparam logic [1:0] FUNC_ERASE  = 2'd0;
  localparam logic [1:0] FUNC_DRAW   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Configuration register indexes.
  localparam int CFG_OLD_ORIGIN = 0;
  localparam int CFG_OLD_AXIS_X = 1;
  localparam int CFG_OLD_AXIS_Y = 2;
  localparam int CFG_OLD_AXIS_Z = 3;
  localparam int CFG_NEW_ORIGIN = 4;
  localparam int CFG_NEW_AXIS_X = 5;
  localparam int CFG_NEW_AXIS_Y = 6;
  localparam int CFG_NEW_AXIS_Z = 7;
  localparam int CFG_COUNT      = 8;
  localparam int CFG_IDX_W      = 4;
  localparam int REG_W          = 63;

  // Fixed-point widths of the transform datapath.
  localparam int QW = 21;  // one packed Q12.8 lane
  localparam int PW = 30;  // lane times a 9-bit signed model coordinate
  localparam int SW = 32;  // sum of origin and three products
  localparam int FW = 24;  // fine coordinate after dropping the fraction
  localparam int BW = 16;  // bounding box coordinate
  localparam int FRAC_BITS = 8;

  localparam logic [7:0] SOLID_MIN = 8'd16;

  // Read-modify-write request toward the occupancy store.
  typedef struct packed {
    logic       valid;
    logic       set;
    logic [2:0] bit_sel;
  } store_req_t;

endpackage

// ----- sv/vos_xform.sv -----
// One axis of the affine transform: origin plus three products, truncated to fine units.
module vos_xform (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [vos_pkg::QW-1:0]    org,
  input  logic signed [vos_pkg::QW-1:0]    coef_x,
  input  logic signed [vos_pkg::QW-1:0]    coef_y,
  input  logic signed [vos_pkg::QW-1:0]    coef_z,
  input  logic        [7:0]                mx,
  input  logic        [7:0]                my,
  input  logic        [7:0]                mz,
  output logic signed [vos_pkg::FW-1:0]    fine
);

  logic signed [vos_pkg::QW-1:0] org_q;
  logic signed [vos_pkg::PW-1:0] prod_x;
  logic signed [vos_pkg::PW-1:0] prod_y;
  logic signed [vos_pkg::PW-1:0] prod_z;
  logic signed [vos_pkg::SW-1:0] sum_a;
  logic signed [vos_pkg::SW-1:0] sum_b;
  logic signed [vos_pkg::SW-1:0] sum_all;
  logic signed [vos_pkg::SW-1:0] sum_adj;

  // Round toward zero: bias negative sums before the arithmetic shift.
  always_comb begin
    sum_adj = sum_all;
    if (sum_all[vos_pkg::SW-1]) begin
      sum_adj = sum_all + $signed(vos_pkg::SW'((1 << vos_pkg::FRAC_BITS) - 1));
    end
  end

  // Multiply stage, two adder stages and the truncation stage.
  always_ff @(posedge clk) begin
    if (en) begin
      org_q   <= org;
      prod_x  <= coef_x * $signed({1'b0, mx});
      prod_y  <= coef_y * $signed({1'b0, my});
      prod_z  <= coef_z * $signed({1'b0, mz});
      sum_a   <= vos_pkg::SW'(org_q) + vos_pkg::SW'(prod_x);
      sum_b   <= vos_pkg::SW'(prod_y) + vos_pkg::SW'(prod_z);
      sum_all <= sum_a + sum_b;
      fine    <= vos_pkg::FW'(sum_adj >>> vos_pkg::FRAC_BITS);
    end
  end

endmodule

// ----- sv/vos_store.sv -----
// Byte-per-cell occupancy memory with a clearing sweep and forwarded read-modify-write.
module vos_store #(
  parameter int DEPTH = 8388608,
  parameter int AW    = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vos_pkg::store_req_t  req,
  input  logic [AW-1:0]        idx,
  output logic                 busy
);

  logic [7:0]          mem [DEPTH];
  logic [AW-1:0]       clr_cnt;
  vos_pkg::store_req_t m1_req;
  logic [AW-1:0]       m1_idx;
  vos_pkg::store_req_t m2_req;
  logic [AW-1:0]       m2_idx;
  logic [7:0]          rd_data;
  logic                fwd_valid;
  logic [AW-1:0]       fwd_idx;
  logic [7:0]          fwd_data;
  logic [7:0]          cur_byte;
  logic [7:0]          new_byte;
  logic [7:0]          bit_mask;

  // Take the byte just written when the read raced that write.
  always_comb begin
    cur_byte = rd_data;
    if (fwd_valid && (fwd_idx == m2_idx)) begin
      cur_byte = fwd_data;
    end
    bit_mask = 8'd1 << m2_req.bit_sel;
    new_byte = m2_req.set ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
  end

  // Control: the clearing sweep and the request pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clr_cnt   <= '0;
      m1_req    <= '0;
      m2_req    <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (busy) begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          busy <= 1'b0;
        end else begin
          clr_cnt <= clr_cnt + 1'b1;
        end
      end
      m1_req    <= req;
      m2_req    <= m1_req;
      fwd_valid <= m2_req.valid;
    end
  end

  // Request addresses and the forwarding copy of the last write.
  always_ff @(posedge clk) begin
    m1_idx   <= idx;
    m2_idx   <= m1_idx;
    fwd_idx  <= m2_idx;
    fwd_data <= new_byte;
  end

  // Memory: one registered read and one write per cycle.
  always_ff @(posedge clk) begin
    rd_data <= mem[m1_idx];
    if (busy) begin
      mem[clr_cnt] <= 8'd0;
    end else if (m2_req.valid) begin
      mem[m2_idx] <= new_byte;
    end
  end

endmodule

// ----- sv/voxel_occupancy_scatter.sv -----
// A finish request passes stages s1 to s5 before its region is registered out.
// Throughput: one request per cycle, set by the 4-stage transform pipeline and
// the single read and write port of the occupancy memory (RMW forwarded).
// A finish stalls input only while the previous region still waits at the output.
// Reset: synchronous; afterwards a clearing pass zeroes all VOL_X*VOL_Y*VOL_Z
// bytes of the memory, one byte a cycle, during which no request is accepted.
module voxel_occupancy_scatter #(
  parameter int VOL_X     = 256,
  parameter int VOL_Y     = 128,
  parameter int VOL_Z     = 256,
  parameter int MODEL_DIM = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic [7:0]                      model_x,
  input  logic [7:0]                      model_y,
  input  logic [7:0]                      model_z,
  input  logic [7:0]                      material,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      region_x,
  output logic [6:0]                      region_y,
  output logic [7:0]                      region_z,
  output logic [8:0]                      span_x,
  output logic [7:0]                      span_y,
  output logic [8:0]                      span_z,
  input  logic                            cfg_we,
  input  logic [vos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vos_pkg::REG_W-1:0]       cfg_data
);

  localparam int DEPTH = VOL_X * VOL_Y * VOL_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(VOL_X);
  localparam int CYW   = $clog2(VOL_Y);
  localparam int CZW   = $clog2(VOL_Z);
  localparam int FW    = vos_pkg::FW;
  localparam int BW    = vos_pkg::BW;
  localparam int QW    = vos_pkg::QW;

  logic [vos_pkg::REG_W-1:0] cfg_reg [vos_pkg::CFG_COUNT];

  logic                 busy;
  logic                 stall;
  logic                 adv;
  logic                 useful;

  logic                 s1_v, s2_v, s3_v, s4_v, s5_v;
  logic                 s1_fin, s2_fin, s3_fin, s4_fin, s5_fin;
  logic                 s1_draw, s2_draw, s3_draw, s4_draw, s5_draw;
  logic [7:0]           s1_mx, s1_my, s1_mz;

  logic [vos_pkg::REG_W-1:0] sel_org, sel_ax, sel_ay, sel_az;
  logic signed [FW-1:0] fine [3];

  logic                 in_range;
  logic [CXW-1:0]       cx;
  logic [CYW-1:0]       cy;
  logic [CZW-1:0]       cz;
  logic [AW-1:0]        store_idx;
  vos_pkg::store_req_t  store_req;

  logic signed [BW-1:0] box_low  [3];
  logic signed [BW-1:0] box_high [3];
  logic signed [BW-1:0] box_pt   [3];
  logic signed [BW-1:0] box_top  [3];
  logic signed [BW-1:0] lo_t     [3];
  logic signed [BW-1:0] hi_t     [3];
  logic signed [BW-1:0] lo_c     [3];
  logic signed [BW-1:0] hi_c     [3];
  logic        [BW:0]   span     [3];
  logic                 emit;

  function automatic logic signed [BW-1:0] sat16(input logic signed [FW-1:0] v);
    logic signed [BW-1:0] r;
    r = BW'(v);
    if (v > $signed(FW'(32767))) begin
      r = 16'sh7FFF;
    end else if (v < -$signed(FW'(32768))) begin
      r = 16'sh8000;
    end
    return r;
  endfunction

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vos_pkg::CFG_COUNT; i++) begin
        cfg_reg[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < vos_pkg::CFG_IDX_W'(vos_pkg::CFG_COUNT))) begin
      cfg_reg[cfg_index[$clog2(vos_pkg::CFG_COUNT)-1:0]] <= cfg_data;
    end
  end

  // Only a finish waiting on a full output register holds the pipeline.
  assign stall    = s5_v && s5_fin && out_valid && !out_ready;
  assign adv      = !stall;
  assign in_ready = !busy && adv;

  // Requests that change nothing are dropped at the door.
  always_comb begin
    useful = 1'b0;
    unique case (func)
      vos_pkg::FUNC_ERASE, vos_pkg::FUNC_DRAW: begin
        useful = (material >= vos_pkg::SOLID_MIN)
              && ({1'b0, model_x} < 9'(MODEL_DIM))
              && ({1'b0, model_y} < 9'(MODEL_DIM))
              && ({1'b0, model_z} < 9'(MODEL_DIM));
      end
      vos_pkg::FUNC_FINISH: begin
        useful = 1'b1;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  // Control pipeline alongside the transform stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid && in_ready && useful;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fin  <= (func == vos_pkg::FUNC_FINISH);
      s1_draw <= (func == vos_pkg::FUNC_DRAW);
      s1_mx   <= model_x;
      s1_my   <= model_y;
      s1_mz   <= model_z;
      s2_fin  <= s1_fin;
      s3_fin  <= s2_fin;
      s4_fin  <= s3_fin;
      s5_fin  <= s4_fin;
      s2_draw <= s1_draw;
      s3_draw <= s2_draw;
      s4_draw <= s3_draw;
      s5_draw <= s4_draw;
    end
  end

  // Draw uses the new transform, erase the old one.
  always_comb begin
    if (s1_draw) begin
      sel_org = cfg_reg[vos_pkg::CFG_NEW_ORIGIN];
      sel_ax  = cfg_reg[vos_pkg::CFG_NEW_AXIS_X];
      sel_ay  = cfg_reg[vos_pkg::CFG_NEW_AXIS_Y];
      sel_az  = cfg_reg[vos_pkg::CFG_NEW_AXIS_Z];
    end else begin
      sel_org = cfg_reg[vos_pkg::CFG_OLD_ORIGIN];
      sel_ax  = cfg_reg[vos_pkg::CFG_OLD_AXIS_X];
      sel_ay  = cfg_reg[vos_pkg::CFG_OLD_AXIS_Y];
      sel_az  = cfg_reg[vos_pkg::CFG_OLD_AXIS_Z];
    end
  end

  // One transform lane per axis.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    vos_xform u_xform (
      .clk    (clk),
      .en     (adv),
      .org    ($signed(sel_org[QW*a +: QW])),
      .coef_x ($signed(sel_ax[QW*a +: QW])),
      .coef_y ($signed(sel_ay[QW*a +: QW])),
      .coef_z ($signed(sel_az[QW*a +: QW])),
      .mx     (s1_mx),
      .my     (s1_my),
      .mz     (s1_mz),
      .fine   (fine[a])
    );
  end

  // Range check and byte address of the fine point.
  always_comb begin
    in_range = !fine[0][FW-1] && (fine[0] < $signed(FW'(2 * VOL_X)))
            && !fine[1][FW-1] && (fine[1] < $signed(FW'(2 * VOL_Y)))
            && !fine[2][FW-1] && (fine[2] < $signed(FW'(2 * VOL_Z)));
    cx = fine[0][CXW:1];
    cy = fine[1][CYW:1];
    cz = fine[2][CZW:1];
    store_idx = AW'(cx) + AW'(cy) * AW'(VOL_X) + AW'(cz) * AW'(VOL_X * VOL_Y);
    store_req.valid   = s5_v && !s5_fin && in_range;
    store_req.set     = s5_draw;
    store_req.bit_sel = {fine[2][0], fine[1][0], fine[0][0]};
  end

  vos_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (store_req),
    .idx  (store_idx),
    .busy (busy)
  );

  // Region from the box: halve toward zero, clamp to the coarse volume.
  always_comb begin
    box_top[0] = $signed(BW'(VOL_X - 1));
    box_top[1] = $signed(BW'(VOL_Y - 1));
    box_top[2] = $signed(BW'(VOL_Z - 1));
    emit = (box_high[0] != '0) || (box_high[1] != '0) || (box_high[2] != '0);
    for (int a = 0; a < 3; a++) begin
      box_pt[a] = sat16(fine[a]);
      lo_t[a] = box_low[a] + $signed({{(BW-1){1'b0}}, box_low[a][BW-1]});
      hi_t[a] = box_high[a] + $signed({{(BW-1){1'b0}}, box_high[a][BW-1]});
      lo_c[a] = lo_t[a] >>> 1;
      hi_c[a] = hi_t[a] >>> 1;
      if (lo_c[a] < 0) begin
        lo_c[a] = '0;
      end
      if (hi_c[a] > box_top[a]) begin
        hi_c[a] = box_top[a];
      end
      span[a] = {hi_c[a][BW-1], hi_c[a]} - {lo_c[a][BW-1], lo_c[a]} + 1'b1;
    end
  end

  // Bounding box: widened by every voxel, reset by every finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_low[a]  <= box_top[a];
        box_high[a] <= '0;
      end
    end else if (s5_v && adv) begin
      for (int a = 0; a < 3; a++) begin
        if (s5_fin) begin
          box_low[a]  <= box_top[a];
          box_high[a] <= '0;
        end else begin
          if (box_pt[a] < box_low[a]) begin
            box_low[a] <= box_pt[a];
          end
          if (box_pt[a] > box_high[a]) begin
            box_high[a] <= box_pt[a];
          end
        end
      end
    end
  end

  // Output register for the region request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s5_v && s5_fin && adv && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_v && s5_fin && adv && emit) begin
      region_x <= lo_c[0][7:0];
      region_y <= lo_c[1][6:0];
      region_z <= lo_c[2][7:0];
      span_x   <= span[0][8:0];
      span_y   <= span[1][7:0];
      span_z   <= span[2][8:0];
    end
  end

endmodule
